>>> design/float_sum_wide_accumulator_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the float sum accumulator
// Shared assertion helpers used by the modules that check their own logic.
// ----------------------------------------------------------------------------
`ifndef FLOAT_SUM_WIDE_ACCUMULATOR_CORE_DEFINES_SVH
`define FLOAT_SUM_WIDE_ACCUMULATOR_CORE_DEFINES_SVH

// Checks that a property holds at every clock edge outside reset.
`define FSA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Checks that an antecedent implies a consequent in the next cycle.
`define FSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/fsa_pkg.sv
// ----------------------------------------------------------------------------
// Float sum accumulator package
// Shared types and constants for the front, queue and back parts.
// ----------------------------------------------------------------------------
package fsa_pkg;

  localparam logic [31:0] CanonQnan = 32'h7FC0_0000;
  localparam logic [31:0] PosInf = 32'h7F80_0000;
  localparam logic [31:0] NegInf = 32'hFF80_0000;

  typedef enum logic [1:0] {
    CLS_ZERO = 2'd0,
    CLS_NUM  = 2'd1,
    CLS_INF  = 2'd2,
    CLS_NAN  = 2'd3
  } cls_e;

  // A classified sample, already widened to double precision.
  typedef struct packed {
    cls_e        cls;
    logic        sign;
    logic [11:0] exp;
    logic [52:0] mant;
    logic        last;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } slot_t;

endpackage

>>> design/float_sum_wide_accumulator_core.sv
// Path: an input transfer goes through the front register and then the queue; the back end loads
// the result as it takes the last item.
// Throughput: one item per cycle unless a stall holds the input; the double add is combinational,
// and the total is narrowed to single precision from a register on the output side.
// Reset: asynchronous, active low; clears the queue, the result valid and the total to +0.0.
// ----------------------------------------------------------------------------
// Float sum accumulator core
// Sums single-precision samples in a double accumulator, emitting on last.
// ----------------------------------------------------------------------------
module float_sum_wide_accumulator_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] sample_bits_i,
  input  logic        has_sample_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] sum_bits_o
);

  fsa_pkg::slot_t f2q, q2b;
  logic q_stall, b_stall;

  fsa_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .sample_bits_i, .has_sample_i,
    .last_i, .slot_o(f2q), .slot_stall_i(q_stall)
  );

  fsa_queue u_queue (
    .clk_i, .rst_ni, .wr_i(f2q), .wr_stall_o(q_stall), .rd_o(q2b), .rd_stall_i(b_stall)
  );

  fsa_back u_back (
    .clk_i, .rst_ni, .slot_i(q2b), .slot_stall_o(b_stall), .out_valid_o,
    .out_stall_i, .sum_bits_o
  );

endmodule

>>> design/fsa_front.sv
// ----------------------------------------------------------------------------
// Float sum front end
// Accepts samples, widens each one to double exactly and classifies it.
// ----------------------------------------------------------------------------
module fsa_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [31:0]         sample_bits_i,
  input  logic                has_sample_i,
  input  logic                last_i,
  output fsa_pkg::slot_t      slot_o,
  input  logic                slot_stall_i
);

  logic           valid_q, valid_d;
  fsa_pkg::item_t item_q, item_d;
  fsa_pkg::item_t it;
  logic [7:0]  e8;
  logic [22:0] f23;
  logic [4:0]  lz;
  logic [22:0] fn;

  assign e8  = sample_bits_i[30:23];
  assign f23 = sample_bits_i[22:0];

  always_comb begin
    lz = 5'd0;
    for (int i = 22; i >= 0; i--) begin
      if (f23[i]) begin
        lz = 5'(22 - i);
        break;
      end
    end
    fn = f23 << (lz + 5'd1);
  end

  always_comb begin
    it.sign = sample_bits_i[31];
    it.last = last_i;
    it.exp  = 12'd0;
    it.mant = 53'd0;
    if (!has_sample_i) begin
      it.cls = fsa_pkg::CLS_ZERO;
      it.sign = 1'b0;
    end else if (e8 == 8'hFF) begin
      it.cls = (f23 != 23'd0) ? fsa_pkg::CLS_NAN : fsa_pkg::CLS_INF;
    end else if (e8 == 8'd0 && f23 == 23'd0) begin
      it.cls = fsa_pkg::CLS_ZERO;
    end else if (e8 == 8'd0) begin
      it.cls  = fsa_pkg::CLS_NUM;
      it.exp  = 12'(896 - 32'(lz));
      it.mant = {1'b1, fn, 29'd0};
    end else begin
      it.cls  = fsa_pkg::CLS_NUM;
      it.exp  = {4'd0, e8} + 12'd896;
      it.mant = {1'b1, f23, 29'd0};
    end
  end

  assign in_stall_o  = valid_q && slot_stall_i;
  assign slot_o.valid = valid_q;
  assign slot_o.item  = item_q;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (!in_stall_o) begin
      valid_d = in_valid_i;
      item_d  = it;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

endmodule

>>> design/fsa_queue.sv
// ----------------------------------------------------------------------------
// Float sum item queue
// A two-entry queue that decouples the front end from the accumulator.
// ----------------------------------------------------------------------------
`include "float_sum_wide_accumulator_core_defines.svh"

module fsa_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  fsa_pkg::slot_t wr_i,
  output logic           wr_stall_o,
  output fsa_pkg::slot_t rd_o,
  input  logic           rd_stall_i
);

  fsa_pkg::item_t mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign wr_stall_o = (cnt_q == 2'd2);
  assign push = wr_i.valid && !wr_stall_o;
  assign pop  = (cnt_q != 2'd0) && !rd_stall_i;
  assign rd_o.valid = (cnt_q != 2'd0);
  assign rd_o.item  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= wr_i.item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  `FSA_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q != 2'd3, "queue count out of range")
  `FSA_ASSERT_NEXT(a_full_hold, clk_i, rst_ni, cnt_q == 2'd2 && rd_stall_i,
    cnt_q == 2'd2, "full queue lost an entry")
  `FSA_ASSERT(a_ptr_match, clk_i, rst_ni,
    (cnt_q == 2'd1) == (wp_q != rp_q), "queue pointers disagree with count")

endmodule

>>> design/fsa_back.sv
// ----------------------------------------------------------------------------
// Float sum accumulator back end
// Adds each item into the double accumulator and narrows the total on last.
// ----------------------------------------------------------------------------
`include "float_sum_wide_accumulator_core_defines.svh"

module fsa_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  fsa_pkg::slot_t slot_i,
  output logic           slot_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [31:0]    sum_bits_o
);

  // Accumulator in unpacked form.
  fsa_pkg::cls_e acc_cls_q, acc_cls_d;
  logic        acc_sign_q, acc_sign_d;
  logic [11:0] acc_exp_q, acc_exp_d;
  logic [52:0] acc_mant_q, acc_mant_d;
  logic        out_valid_q;

  // Final total of an image, held until its transfer.
  fsa_pkg::cls_e fin_cls_q;
  logic        fin_sign_q;
  logic [11:0] fin_exp_q;
  logic [52:0] fin_mant_q;

  fsa_pkg::item_t b;
  logic        take;

  // Add datapath.
  logic        big_a;
  logic        sa, sb;
  logic [11:0] ea, eb;
  logic [52:0] ma, mb;
  logic [11:0] diff;
  logic [55:0] xa, xb;
  logic [56:0] sum;
  logic [5:0]  lz;
  logic [56:0] nrm;
  logic signed [13:0] ne;
  logic [52:0] rm;
  logic [53:0] rmr;
  logic        g, st;
  logic [55:0] shifted;
  logic        sticky_sh;

  fsa_pkg::cls_e r_cls;
  logic        r_sign;
  logic [11:0] r_exp;
  logic [52:0] r_mant;

  assign b = slot_i.item;
  assign slot_stall_o = out_valid_q && out_stall_i;
  assign take = slot_i.valid && !slot_stall_o;

  always_comb begin
    big_a = (acc_exp_q > b.exp) || (acc_exp_q == b.exp && acc_mant_q >= b.mant);
    sa = big_a ? acc_sign_q : b.sign;
    ea = big_a ? acc_exp_q : b.exp;
    ma = big_a ? acc_mant_q : b.mant;
    sb = big_a ? b.sign : acc_sign_q;
    eb = big_a ? b.exp : acc_exp_q;
    mb = big_a ? b.mant : acc_mant_q;
    diff = ea - eb;
    xa = {ma, 3'b000};
    if (diff > 12'd55) begin
      shifted = 56'd0;
      sticky_sh = 1'b1;
    end else begin
      shifted = {mb, 3'b000} >> diff[5:0];
      sticky_sh = (({mb, 3'b000} & ~({56{1'b1}} << diff[5:0])) != 56'd0);
    end
    xb = {shifted[55:1], shifted[0] | sticky_sh};
    if (sa == sb) sum = {1'b0, xa} + {1'b0, xb};
    else sum = {1'b0, xa} - {1'b0, xb};
    lz = 6'd57;
    for (int i = 0; i <= 56; i++) begin
      if (sum[i]) lz = 6'(56 - i);
    end
    // Keep the exponent at or above one for results in the subnormal range.
    if ($signed({2'b00, ea}) + 14'sd1 - $signed({8'd0, lz}) < 14'sd1) begin
      lz = 6'(ea);
    end
    nrm = sum << lz;
    ne = $signed({2'b00, ea}) + 14'sd1 - $signed({8'd0, lz});
    rm = nrm[56:4];
    g  = nrm[3];
    st = nrm[2:0] != 3'd0;
    rmr = {1'b0, rm} + 54'(g && (st || rm[0]));
    r_sign = sa;
    r_cls  = fsa_pkg::CLS_NUM;
    r_exp  = ne[11:0];
    r_mant = rmr[52:0];
    if (rmr[53]) begin
      r_mant = rmr[53:1];
      r_exp  = ne[11:0] + 12'd1;
    end
    if (sum == 57'd0) begin
      r_cls = fsa_pkg::CLS_ZERO;
      r_sign = 1'b0;
    end else if (!r_mant[52]) begin
      r_exp = 12'd0;
    end
    if (r_cls == fsa_pkg::CLS_NUM && r_exp >= 12'd2047) begin
      r_cls = fsa_pkg::CLS_INF;
    end
  end

  always_comb begin
    acc_cls_d = acc_cls_q;
    acc_sign_d = acc_sign_q;
    acc_exp_d = acc_exp_q;
    acc_mant_d = acc_mant_q;
    if (acc_cls_q == fsa_pkg::CLS_NAN || b.cls == fsa_pkg::CLS_NAN) begin
      acc_cls_d = fsa_pkg::CLS_NAN;
    end else if (acc_cls_q == fsa_pkg::CLS_INF && b.cls == fsa_pkg::CLS_INF) begin
      if (acc_sign_q != b.sign) acc_cls_d = fsa_pkg::CLS_NAN;
    end else if (acc_cls_q == fsa_pkg::CLS_INF) begin
      acc_cls_d = acc_cls_q;
    end else if (b.cls == fsa_pkg::CLS_INF) begin
      acc_cls_d = fsa_pkg::CLS_INF;
      acc_sign_d = b.sign;
    end else if (b.cls == fsa_pkg::CLS_ZERO) begin
      acc_cls_d = acc_cls_q;
      if (acc_cls_q == fsa_pkg::CLS_ZERO) acc_sign_d = acc_sign_q & b.sign;
    end else if (acc_cls_q == fsa_pkg::CLS_ZERO) begin
      acc_cls_d = b.cls;
      acc_sign_d = b.sign;
      acc_exp_d = b.exp;
      acc_mant_d = b.mant;
    end else begin
      acc_cls_d = r_cls;
      acc_sign_d = r_sign;
      acc_exp_d = r_exp;
      acc_mant_d = r_mant;
    end
  end

  // Narrowing of the held total to single precision.
  logic signed [13:0] fe;
  logic [5:0]  rsh;
  logic [52:0] fm;
  logic [24:0] keep;
  logic        fg, fs;
  logic [25:0] kr;
  logic [31:0] nb;

  always_comb begin
    fe = $signed({2'b00, fin_exp_q}) - 14'sd896;
    rsh = 6'd0;
    fm = fin_mant_q;
    if (fe < 14'sd1) begin
      if (fe < -14'sd25) rsh = 6'd26;
      else rsh = 6'(14'sd1 - fe);
    end
    keep = 25'({1'b0, fm[52:29]} >> rsh);
    fg = (rsh == 6'd0) ? fm[28] : (rsh > 6'd24 ? (rsh == 6'd24 ? fm[52] : 1'b0)
         : fm[6'd28 + rsh]);
    fs = ((fm & ~({53{1'b1}} << (6'd28 + rsh))) != 53'd0);
    kr = {1'b0, keep} + 26'(fg && (fs || keep[0]));
    if (fe < 14'sd1) begin
      nb = {fin_sign_q, 8'(kr[23]), kr[22:0]};
    end else begin
      if (kr[24]) nb = {fin_sign_q, 8'(fe + 14'sd1), kr[23:1]};
      else nb = {fin_sign_q, 8'(fe), kr[22:0]};
      if (fe > 14'sd254 || (fe == 14'sd254 && kr[24])) begin
        nb = fin_sign_q ? fsa_pkg::NegInf : fsa_pkg::PosInf;
      end
    end
    case (fin_cls_q)
      fsa_pkg::CLS_NAN:  nb = fsa_pkg::CanonQnan;
      fsa_pkg::CLS_INF:  nb = fin_sign_q ? fsa_pkg::NegInf : fsa_pkg::PosInf;
      fsa_pkg::CLS_ZERO: nb = {fin_sign_q, 31'd0};
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_cls_q  <= fsa_pkg::CLS_ZERO;
      acc_sign_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!slot_stall_o) out_valid_q <= take && b.last;
      if (take) begin
        if (b.last) begin
          acc_cls_q  <= fsa_pkg::CLS_ZERO;
          acc_sign_q <= 1'b0;
        end else begin
          acc_cls_q  <= acc_cls_d;
          acc_sign_q <= acc_sign_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      acc_exp_q  <= acc_exp_d;
      acc_mant_q <= acc_mant_d;
      if (b.last) begin
        fin_cls_q  <= acc_cls_d;
        fin_sign_q <= acc_sign_d;
        fin_exp_q  <= acc_exp_d;
        fin_mant_q <= acc_mant_d;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign sum_bits_o  = nb;

  `FSA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_q && out_stall_i,
    out_valid_q && $stable(sum_bits_o), "stalled result changed")
  `FSA_ASSERT_NEXT(a_clear_on_last, clk_i, rst_ni, take && b.last,
    acc_cls_q == fsa_pkg::CLS_ZERO && !acc_sign_q, "accumulator not cleared after last")
  `FSA_ASSERT(a_no_take_stalled, clk_i, rst_ni, !(take && out_valid_q && out_stall_i),
    "item taken while result stalled")

endmodule

>>> verif/float_sum_wide_accumulator_core_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Float sum accumulator checker
// Watches both channels of the accumulator core. For every input transfer
// with a sample it adds the widened sample into its own double-precision
// total. On the last item it rounds that total to single precision and queues
// the sum. Each output transfer is compared with the oldest queued sum.
// ----------------------------------------------------------------------------
module float_sum_wide_accumulator_core_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [31:0] sample_bits_i,
  input  logic        has_sample_i,
  input  logic        last_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [31:0] sum_bits_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          sums_seen_o,
  output int          special_sums_o
);

  real         total_acc;
  logic [31:0] sum_queue[$];

  function automatic logic [63:0] widen_single(logic [31:0] b);
    logic        s;
    logic [7:0]  e;
    logic [22:0] m;
    int          p;
    logic [63:0] mm;
    s = b[31];
    e = b[30:23];
    m = b[22:0];
    if (e == 8'hFF) begin
      if (m == 0) return {s, 11'h7FF, 52'd0};
      return {s, 11'h7FF, 1'b1, m, 28'd0};
    end
    if (e == 0) begin
      if (m == 0) return {s, 63'd0};
      p = 0;
      for (int i = 0; i < 23; i++) if (m[i]) p = i;
      mm = 64'(m) << (52 - p);
      return {s, 11'(p - 149 + 1023), mm[51:0]};
    end
    return {s, 11'(e) + 11'd896, m, 29'd0};
  endfunction

  function automatic logic [31:0] narrow_double(logic [63:0] d);
    logic        s;
    int          ex;
    int          u;
    int          sh;
    int          base;
    logic [63:0] sig;
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    logic [63:0] r;
    s = d[63];
    ex = int'(d[62:52]);
    if (ex == 2047) begin
      return (d[51:0] != 0) ? fsa_pkg::CanonQnan : (s ? fsa_pkg::NegInf : fsa_pkg::PosInf);
    end
    if (ex == 0) return {s, 31'd0};
    u = ex - 1023;
    if (u > 127) return s ? fsa_pkg::NegInf : fsa_pkg::PosInf;
    sig = {11'd0, 1'b1, d[51:0]};
    if (u >= -126) begin
      sh = 29;
      base = u + 126;
    end else begin
      sh = -u - 97;
      base = 0;
    end
    if (sh > 60) return {s, 31'd0};
    q = sig >> sh;
    rem = sig & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && q[0])) q = q + 64'd1;
    r = (64'(base) << 23) + q;
    if (r >= 64'h7F80_0000) return s ? fsa_pkg::NegInf : fsa_pkg::PosInf;
    return {s, r[30:0]};
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [31:0] want;
    if (!rst_ni) begin
      total_acc = 0.0;
      sum_queue.delete();
      fail_count_o = 0;
      pending_o = 0;
      sums_seen_o = 0;
      special_sums_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        sums_seen_o++;
        if (sum_queue.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("ERROR: unexpected sum transfer %h", sum_bits_i);
        end else begin
          want = sum_queue.pop_front();
          if (want[30:23] == 8'hFF || want[30:23] == 8'h00) special_sums_o++;
          if (want !== sum_bits_i) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("ERROR: sum_bits expected %h actual %h", want, sum_bits_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (has_sample_i) total_acc = total_acc + $bitstoreal(widen_single(sample_bits_i));
        if (last_i) begin
          sum_queue.push_back(narrow_double($realtobits(total_acc)));
          total_acc = 0.0;
        end
      end
      pending_o = sum_queue.size();
    end
  end

endmodule

>>> verif/float_sum_wide_accumulator_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Float sum accumulator testbench
// Drives directed images with special values and then random images of
// mostly short length, with bursty input and a patterned output stall,
// including one long hold-off that backs the core up.
// ----------------------------------------------------------------------------
module float_sum_wide_accumulator_core_tb;

  localparam int CycleLimit = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] sample_bits_i = '0;
  logic        has_sample_i = 1'b0;
  logic        last_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] sum_bits_o;
  int          fail_count;
  int          pending;
  int          sums_seen;
  int          special_sums;
  int          cycle_count = 0;
  int          items_sent = 0;
  int          burst_left = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  float_sum_wide_accumulator_core dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .sample_bits_i, .has_sample_i,
    .last_i, .out_valid_o, .out_stall_i, .sum_bits_o
  );

  float_sum_wide_accumulator_core_checker checker_inst (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .sample_bits_i,
    .has_sample_i, .last_i, .out_valid_i(out_valid_o), .out_stall_i,
    .sum_bits_i(sum_bits_o), .fail_count_o(fail_count), .pending_o(pending),
    .sums_seen_o(sums_seen), .special_sums_o(special_sums)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Output stall: shifting random pattern, with one long hold-off.
  initial begin
    int mode;
    int hold;
    mode = 0;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (cycle_count == 600) hold = 400;
      if (hold > 0) begin
        hold--;
        out_stall_i <= 1'b1;
      end else begin
        if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 3);
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          2: out_stall_i <= 1'($urandom_range(0, 1));
          default: out_stall_i <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  task automatic send_item(logic [31:0] s, logic h, logic l);
    logic taken;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 2) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    sample_bits_i <= s;
    has_sample_i <= h;
    last_i <= l;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = !in_stall_o;
    end
    items_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] random_sample();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return {1'($urandom), 8'($urandom_range(107, 147)), 23'($urandom)};
    if (k < 70) return $urandom;
    if (k < 78) return {1'($urandom), 8'd0, 23'($urandom)};
    if (k < 84) return {1'($urandom), 8'($urandom_range(250, 254)), 23'($urandom)};
    if (k < 88) return {1'($urandom), 31'h7F80_0000};
    if (k < 91) return {1'($urandom), 8'hFF, 23'($urandom_range(1, 8388607))};
    if (k < 95) return {1'($urandom), 31'd0};
    return {1'($urandom), 8'($urandom_range(1, 30)), 23'($urandom)};
  endfunction

  initial begin
    int len;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Empty image, then a last item without a sample after a sum.
    send_item(32'h3F80_0000, 1'b0, 1'b1);
    send_item(32'h3F80_0000, 1'b1, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b0, 1'b1);
    // Negative zeros only.
    send_item(32'h8000_0000, 1'b1, 1'b0);
    send_item(32'h8000_0000, 1'b1, 1'b1);
    // Largest values overflow on narrowing.
    send_item(32'h7F7F_FFFF, 1'b1, 1'b0);
    send_item(32'h7F7F_FFFF, 1'b1, 1'b1);
    send_item(32'hFF7F_FFFF, 1'b1, 1'b0);
    send_item(32'hFF7F_FFFF, 1'b1, 1'b1);
    // Infinities of opposite sign give NaN, and a NaN sample gives NaN.
    send_item(fsa_pkg::PosInf, 1'b1, 1'b0);
    send_item(fsa_pkg::NegInf, 1'b1, 1'b1);
    send_item(fsa_pkg::NegInf, 1'b1, 1'b1);
    send_item(32'h7F80_0001, 1'b1, 1'b0);
    send_item(32'h3F80_0000, 1'b1, 1'b1);
    send_item(32'hFFFF_FFFF, 1'b1, 1'b1);
    // Subnormal extremes and cancellation.
    send_item(32'h0000_0001, 1'b1, 1'b1);
    send_item(32'h807F_FFFF, 1'b1, 1'b0);
    send_item(32'h0000_0001, 1'b1, 1'b1);
    send_item(32'h4B80_0000, 1'b1, 1'b0);
    send_item(32'h3F80_0000, 1'b1, 1'b0);
    send_item(32'hCB80_0000, 1'b1, 1'b1);
    send_item(32'h0000_0000, 1'b1, 1'b1);

    while (items_sent < 1800) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
      for (int i = 0; i < len; i++)
        send_item(random_sample(), $urandom_range(0, 9) != 0, i == len - 1);
    end
    in_valid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("Sent %0d samples, checked %0d sums (%0d zero, subnormal, inf or NaN).",
             items_sent, sums_seen, special_sums);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/fsa_pkg.sv
design/fsa_front.sv
design/fsa_queue.sv
design/fsa_back.sv
design/float_sum_wide_accumulator_core.sv
verif/float_sum_wide_accumulator_core_checker.sv
verif/float_sum_wide_accumulator_core_tb.sv
